[rtl/core/conv_array_address_generator_defines.svh]
// Assertion macros for the convolution array address generator.
// Used by cag_back under rtl/core. Each module must have i_clk and i_rst_n.
`ifndef CONV_ARRAY_ADDRESS_GENERATOR_DEFINES_SVH
`define CONV_ARRAY_ADDRESS_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CAG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cag assertion failed");

// Next-cycle implication, checked outside reset.
`define CAG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cag assertion failed");

`endif

[rtl/core/cag_pkg.sv]
// Shared types and constants for the convolution array address generator.
// No dependencies.
package cag_pkg;

    localparam int          DEF_ROWS         = 16;
    localparam int          DEF_PIPE_DEPTH   = 2;
    localparam logic [31:0] DEF_BASE_ADDRESS = 32'h0;

    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 40;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CONV_KERNEL      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_FLAGS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLOW_LOOP_TIMES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VERTICAL_STEPS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZONTAL_STEPS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_STEPS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OPERAND_BASES    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RESULT_BASES     = 3'd7;

    // stream flag bits
    localparam int FLAG_ACTIVE = 0;
    localparam int FLAG_DONE   = 1;

    typedef struct packed {
        logic start_req;
        logic write_valid;
        logic write_last;
        logic last_flow;
        logic scheduler_busy;
        logic choose_vertical;
    } t_in_item;

    typedef struct packed {
        logic [31:0] address;
        logic        read_strobe;
        logic        write_strobe;
        logic        read_last;
        logic        write_last_out;
        logic        raw_last;
        logic        register_file_clear;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  conv_kernel;
        logic [4:0]  control_flags;
        logic [15:0] flow_loop_times;
        logic [27:0] vertical_steps;
        logic [27:0] horizontal_steps;
        logic [27:0] output_steps;
        logic [39:0] operand_bases;
        logic [39:0] result_bases;
    } t_cmd;

    typedef struct packed {
        logic        valid;
        logic        write;
        logic        last;
        logic [31:0] addr;
    } t_token;

endpackage

[rtl/core/cag_fifo.sv]
// Short item queue between the front and back parts.
// Depends on cag_pkg.
module cag_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cag_pkg::t_in_item i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output cag_pkg::t_in_item o_data
);
    import cag_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_in_item               r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]       r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]       r_count;
    logic                   wr_en, rd_en;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(wr_en) - CNT_W'(rd_en);
        end
    end

endmodule

[rtl/core/cag_front.sv]
// Front part: configuration registers and input transfer acceptance.
// Depends on cag_pkg; feeds cag_fifo.
module cag_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    input  cag_pkg::t_in_item                  i_in,
    output logic                               full,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cag_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cag_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output cag_pkg::t_cmd                      o_cfg,
    input  logic                               i_q_full,
    output logic                               o_q_push,
    output cag_pkg::t_in_item                  o_q_data
);
    import cag_pkg::*;

    t_cmd r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;
    assign full        = i_q_full;
    assign o_q_push    = push && !i_q_full;
    assign o_q_data    = i_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CONV_KERNEL:      r_cfg.conv_kernel      <= i_cfg_data[2:0];
                REG_CONTROL_FLAGS:    r_cfg.control_flags    <= i_cfg_data[4:0];
                REG_FLOW_LOOP_TIMES:  r_cfg.flow_loop_times  <= i_cfg_data[15:0];
                REG_VERTICAL_STEPS:   r_cfg.vertical_steps   <= i_cfg_data[27:0];
                REG_HORIZONTAL_STEPS: r_cfg.horizontal_steps <= i_cfg_data[27:0];
                REG_OUTPUT_STEPS:     r_cfg.output_steps     <= i_cfg_data[27:0];
                REG_OPERAND_BASES:    r_cfg.operand_bases    <= i_cfg_data[39:0];
                REG_RESULT_BASES:     r_cfg.result_bases     <= i_cfg_data[39:0];
                default:              r_cfg <= r_cfg;
            endcase
        end
    end

endmodule

[rtl/core/cag_back.sv]
// Back part: counters, token pipeline and result register.
// Depends on cag_pkg and the assertion macro header.
`include "conv_array_address_generator_defines.svh"
module cag_back #(
    parameter int          ROWS         = cag_pkg::DEF_ROWS,
    parameter int          PIPE_DEPTH   = cag_pkg::DEF_PIPE_DEPTH,
    parameter logic [31:0] BASE_ADDRESS = cag_pkg::DEF_BASE_ADDRESS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_q_pop,
    input  cag_pkg::t_in_item  i_item,
    input  cag_pkg::t_cmd      i_cfg,
    output logic               empty,
    input  logic               pop,
    output cag_pkg::t_out_item o_out
);
    import cag_pkg::*;

    localparam int          ROW_W  = $clog2(ROWS);
    localparam logic [16:0] ROWS17 = 17'(ROWS);
    localparam logic        PH_FETCH = 1'b0;
    localparam logic        PH_EXEC  = 1'b1;

    logic               r_phase;
    t_in_item           r_item;
    t_cmd               r_cmd, n_cmd;
    t_token             r_pipe [PIPE_DEPTH];
    t_token             n_pipe [PIPE_DEPTH];
    logic [15:0]        r_vx, r_vch, r_hx, r_hch, n_vx, n_vch, n_hx, n_hch;
    logic [1:0]         r_vfl, r_hfl, n_vfl, n_hfl;
    logic [ROW_W-1:0]   r_row, n_row;
    logic               r_high, r_out_act, r_bias_act, r_bias_beat;
    logic               n_high, n_out_act, n_bias_act, n_bias_beat;
    logic               r_prev_lf, r_prev_v, r_raw_last, r_reg_clr;
    logic               n_prev_lf, n_prev_v, n_raw_last, n_reg_clr;
    logic               r_out_valid;
    t_out_item          r_out, res;
    logic [13:0]        r_vxr, r_vcr, r_hxr, r_hcr;
    logic [19:0]        r_orow;
    logic               fire, fetch;

    // command fields
    logic [2:0]  kern;
    logic [1:0]  mode;
    logic        sh, st, conv, pw;
    logic [15:0] flt, hch_eff;
    logic [13:0] vxs, vcs, hxs, hcs, olo, ohi, vx14;
    logic        vsel, hsel;
    logic [29:0] vprod, hprod;
    logic [33:0] oprod;
    logic [21:0] orow_p;
    logic [19:0] vsum, hsum, osum, bsum;
    logic [15:0] hoff;
    logic [31:0] vaddr, haddr, oaddr, baddr;

    function automatic logic [15:0] at_least_one(input logic [17:0] v);
        return (v[15:0] == 16'd0) ? 16'd1 : v[15:0];
    endfunction

    always_comb begin
        kern    = r_cmd.conv_kernel;
        mode    = r_cmd.control_flags[1:0];
        sh      = r_cmd.control_flags[2];
        st      = r_cmd.control_flags[3];
        conv    = r_cmd.control_flags[4];
        flt     = r_cmd.flow_loop_times;
        pw      = (kern == 3'd1);
        vxs     = r_cmd.vertical_steps[13:0];
        vcs     = r_cmd.vertical_steps[27:14];
        hxs     = r_cmd.horizontal_steps[13:0];
        hcs     = r_cmd.horizontal_steps[27:14];
        olo     = r_cmd.output_steps[13:0];
        ohi     = r_cmd.output_steps[27:14];
        hch_eff = (pw && sh) ? {1'b0, r_hch[15:1]} : r_hch;
        vx14    = r_vx[13:0] + ((sh && kern < 3'd3 && r_vch[0]) ? 14'd8 : 14'd0);
        orow_p  = 22'(r_row) * 22'(olo);
        // second products, from first products registered in the fetch cycle
        vsel    = (flt == (sh ? 16'd2 : 16'd1));
        hsel    = (vsel || pw) && (mode != 2'd2);
        vprod   = vsel ? (30'(r_vxr) * 30'(vcs))
                       : (30'(vxs) * 30'(r_vcr)) + 30'(r_vxr);
        hprod   = hsel ? (30'(r_hxr) * 30'(hcs))
                       : (30'(hxs) * 30'(r_hcr)) + 30'(r_hxr);
        hoff    = (kern == 3'd0) ? (hch_eff + 16'(r_hxr)) : hprod[15:0];
        oprod   = r_orow * ohi;
        vsum    = r_cmd.operand_bases[19:0] + {vprod[15:0], 4'b0};
        hsum    = r_cmd.operand_bases[39:20] + {hoff, 4'b0};
        osum    = r_cmd.result_bases[19:0] + {oprod[15:0], 4'b0} + (r_high ? 20'd16 : 20'd0);
        bsum    = r_cmd.result_bases[39:20] + (r_bias_beat ? 20'd16 : 20'd0);
        vaddr   = BASE_ADDRESS + {12'b0, vsum};
        haddr   = BASE_ADDRESS + {12'b0, hsum};
        oaddr   = BASE_ADDRESS + {12'b0, osum};
        baddr   = BASE_ADDRESS + {12'b0, bsum};
    end

    // result shows the state before this item's update
    always_comb begin
        res.address             = r_pipe[PIPE_DEPTH-1].addr;
        res.read_strobe         = r_pipe[PIPE_DEPTH-1].valid && !r_pipe[PIPE_DEPTH-1].write;
        res.write_strobe        = r_pipe[PIPE_DEPTH-1].valid && r_pipe[PIPE_DEPTH-1].write;
        res.read_last           = res.read_strobe && r_pipe[PIPE_DEPTH-1].last;
        res.write_last_out      = res.write_strobe && r_pipe[PIPE_DEPTH-1].last;
        res.raw_last            = r_raw_last;
        res.register_file_clear = r_reg_clr;
    end

    // next state for one item
    always_comb begin
        logic [15:0] x, ch, x1, ch1, cc;
        logic [1:0]  fl;
        logic [16:0] xc;
        logic [17:0] hcc;
        logic        last, wrap;

        n_cmd = r_cmd;
        n_vx = r_vx; n_vch = r_vch; n_hx = r_hx; n_hch = r_hch;
        n_vfl = r_vfl; n_hfl = r_hfl;
        n_row = r_row; n_high = r_high; n_out_act = r_out_act;
        n_bias_act = r_bias_act; n_bias_beat = r_bias_beat;
        n_prev_v = r_prev_v;
        n_reg_clr = r_reg_clr;
        n_raw_last = 1'b0;
        n_prev_lf = r_item.last_flow;
        n_pipe[0] = '0;
        for (int i = 1; i < PIPE_DEPTH; i++) begin
            n_pipe[i] = r_pipe[i-1];
        end
        x = '0; ch = '0; x1 = '0; ch1 = '0; cc = '0; fl = '0; xc = '0;
        hcc = '0; last = 1'b0; wrap = 1'b0;

        if (res.write_last_out) begin
            n_reg_clr = 1'b1;
        end
        if (r_item.start_req) begin
            n_cmd = i_cfg;
            n_vx = '0; n_vch = '0; n_hx = '0; n_hch = '0;
            n_vfl = '0; n_hfl = '0;
            n_row = '0; n_high = 1'b0;
            n_bias_act = 1'b0; n_bias_beat = 1'b0;
            n_prev_v = 1'b0; n_reg_clr = 1'b0;
        end
        if (r_item.last_flow && !r_prev_lf && conv) begin
            n_bias_act  = 1'b1;
            n_bias_beat = 1'b0;
        end
        if (r_item.write_valid) begin
            n_out_act = 1'b1;
        end

        if (r_out_act || r_item.write_valid) begin
            n_pipe[0].valid = r_item.write_valid;
            n_pipe[0].write = 1'b1;
            n_pipe[0].last  = r_item.write_last;
            n_pipe[0].addr  = oaddr;
            if (r_item.write_valid) begin
                if (sh && !r_high) begin
                    n_high = 1'b1;
                end else begin
                    n_high = 1'b0;
                    n_row  = (r_row == ROW_W'(ROWS - 1)) ? '0 : r_row + 1'b1;
                end
            end
            if (r_item.write_last) begin
                n_out_act = 1'b0;
            end
        end else if (r_bias_act) begin
            n_pipe[0].valid = 1'b1;
            n_pipe[0].addr  = baddr;
            n_bias_act  = !r_bias_beat;
            n_bias_beat = !r_bias_beat;
        end else if (r_item.scheduler_busy && !r_item.last_flow) begin
            x  = r_item.choose_vertical ? n_vx  : n_hx;
            ch = r_item.choose_vertical ? n_vch : n_hch;
            fl = r_item.choose_vertical ? n_vfl : n_hfl;
            if (r_item.choose_vertical != r_prev_v) begin
                fl[FLAG_DONE] = 1'b0;
            end
            n_prev_v = r_item.choose_vertical;
            if (!fl[FLAG_DONE]) begin
                if (!fl[FLAG_ACTIVE]) begin
                    fl[FLAG_ACTIVE] = 1'b1;
                    x  = '0;
                    ch = '0;
                end
                if (r_item.choose_vertical) begin
                    case (kern)
                        3'd3:    xc = 17'd9;
                        3'd5:    xc = 17'd25;
                        3'd7:    xc = 17'd49;
                        default: xc = ROWS17;
                    endcase
                    cc = at_least_one(18'(sh ? {1'b0, flt[15:1]} : flt));
                end else begin
                    xc = (kern >= 3'd3) ? ((mode == 2'd2) ? 17'd1 : 17'(kern)) : ROWS17;
                    if (mode == 2'd2) begin
                        hcc = st ? (18'({flt, 1'b0} >> sh) + 18'd1)
                                 : (18'(flt >> sh) + 18'd2);
                    end else begin
                        hcc = 18'(flt >> ((sh && kern >= 3'd3) ? 1 : 0));
                    end
                    cc = at_least_one(hcc);
                end
                last = (17'(x) + 17'd1) >= xc;
                x1 = x + 16'd1;
                if (17'(x1) < xc) begin
                    x = x1;
                end else begin
                    x   = '0;
                    ch1 = ch + 16'd1;
                    if (ch1 < cc) begin
                        ch = ch1;
                    end else begin
                        ch   = '0;
                        fl   = 2'b10;
                        wrap = 1'b1;
                    end
                end
                if (!r_item.choose_vertical) begin
                    last = wrap;
                end
                n_pipe[0].valid = 1'b1;
                n_pipe[0].last  = last;
                n_pipe[0].addr  = r_item.choose_vertical ? vaddr : haddr;
                n_raw_last      = last;
            end
            if (r_item.choose_vertical) begin
                n_vx = x; n_vch = ch; n_vfl = fl;
            end else begin
                n_hx = x; n_hch = ch; n_hfl = fl;
            end
        end
    end

    assign fetch   = (r_phase == PH_FETCH) && i_q_valid;
    assign fire    = (r_phase == PH_EXEC) && (!r_out_valid || pop);
    assign o_q_pop = fetch;
    assign empty   = !r_out_valid;
    assign o_out   = r_out;

    always_ff @(posedge i_clk) begin
        if (fetch) begin
            r_item <= i_item;
            r_vxr  <= 14'(vx14 * vxs);
            r_vcr  <= 14'(r_vch[13:0] * vcs);
            r_hxr  <= 14'(r_hx[13:0] * hxs);
            r_hcr  <= 14'(hch_eff[13:0] * hcs);
            r_orow <= orow_p[19:0];
        end
        if (fire) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FETCH;
            r_out_valid <= 1'b0;
            r_cmd       <= '0;
            for (int i = 0; i < PIPE_DEPTH; i++) begin
                r_pipe[i] <= '0;
            end
            r_vx <= '0; r_vch <= '0; r_hx <= '0; r_hch <= '0;
            r_vfl <= '0; r_hfl <= '0; r_row <= '0;
            r_high <= 1'b0; r_out_act <= 1'b0;
            r_bias_act <= 1'b0; r_bias_beat <= 1'b0;
            r_prev_lf <= 1'b0; r_prev_v <= 1'b0;
            r_raw_last <= 1'b0; r_reg_clr <= 1'b1;
        end else begin
            if (fetch) begin
                r_phase <= PH_EXEC;
            end else if (fire) begin
                r_phase <= PH_FETCH;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
            if (fire) begin
                r_cmd <= n_cmd;
                r_pipe <= n_pipe;
                r_vx <= n_vx; r_vch <= n_vch; r_hx <= n_hx; r_hch <= n_hch;
                r_vfl <= n_vfl; r_hfl <= n_hfl; r_row <= n_row;
                r_high <= n_high; r_out_act <= n_out_act;
                r_bias_act <= n_bias_act; r_bias_beat <= n_bias_beat;
                r_prev_lf <= n_prev_lf; r_prev_v <= n_prev_v;
                r_raw_last <= n_raw_last; r_reg_clr <= n_reg_clr;
            end
        end
    end

    `CAG_ASSERT_SAME(a_fire_in_exec, fire, r_phase == PH_EXEC)
    `CAG_ASSERT_NEXT(a_result_kept, r_out_valid && !pop, r_out_valid && $stable(r_out))
    `CAG_ASSERT_SAME(a_vflags_sane, 1'b1, r_vfl != 2'b11)
    `CAG_ASSERT_SAME(a_hflags_sane, 1'b1, r_hfl != 2'b11)

endmodule

[rtl/core/conv_array_address_generator.sv]
// Channel        | Handshake                   | Payload
// input items    | push / full                 | i_in  (cag_pkg::t_in_item)
// results        | pop / empty                 | o_out (cag_pkg::t_out_item)
// configuration  | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// In the back part each item has a fetch phase, taking it from the queue and
// forming the first address products, then an execute phase, finishing the
// addresses and updating the counters; the next item is fetched only after it.
// Reset (i_rst_n low, synchronous) clears config, counters and queues; the
// register-file-clear flag comes up set. A full result register holds the
// back part; the two-entry queue keeps input transfers going meanwhile.
// Top level: configuration front, item queue and back part.
// Depends on cag_pkg, cag_front, cag_fifo and cag_back.
module conv_array_address_generator #(
    parameter int          ROWS         = cag_pkg::DEF_ROWS,
    parameter int          PIPE_DEPTH   = cag_pkg::DEF_PIPE_DEPTH,
    parameter logic [31:0] BASE_ADDRESS = cag_pkg::DEF_BASE_ADDRESS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    input  cag_pkg::t_in_item              i_in,
    output logic                           full,
    output logic                           empty,
    input  logic                           pop,
    output cag_pkg::t_out_item             o_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cag_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cag_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cag_pkg::*;

    t_cmd     cfg;
    t_in_item q_in, q_out;
    logic     q_push, q_full, q_valid, q_pop;

    // front: register writes and input transfers
    cag_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_in        (i_in),
        .full        (full),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_in)
    );

    // decouples the two sides
    cag_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_out)
    );

    // back: counters, address math, token pipeline, result register
    cag_back #(
        .ROWS         (ROWS),
        .PIPE_DEPTH   (PIPE_DEPTH),
        .BASE_ADDRESS (BASE_ADDRESS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_item    (q_out),
        .i_cfg     (cfg),
        .empty     (empty),
        .pop       (pop),
        .o_out     (o_out)
    );

endmodule

[test/conv_array_address_generator_tb.sv]
// Self-checking testbench for conv_array_address_generator: an item-level
// predictor of the token pipeline checks every result transfer in order.
// Depends on cag_pkg and the block's RTL.
module conv_array_address_generator_tb;
    import cag_pkg::*;

    localparam int          ROWS  = DEF_ROWS;
    localparam int          DEPTH = DEF_PIPE_DEPTH;
    localparam logic [31:0] BASE  = DEF_BASE_ADDRESS;

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    t_in_item  i_in;
    logic      full;
    logic      empty;
    logic      pop;
    t_out_item o_out;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    conv_array_address_generator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_in        (i_in),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // ------------------------------------------------------------------
    // Predictor state: command latched at start, stream counters, output
    // row walk, bias fetch and the token delay line.
    // ------------------------------------------------------------------
    typedef struct {
        t_cmd        cmd;
        t_token      pipe [DEPTH];
        logic [15:0] vx, vc, hx, hc;
        logic [1:0]  vf, hf;
        int unsigned row;
        bit high_half, out_active, bias_active, bias_beat;
        bit prev_lf, prev_vert, raw_last, reg_clear;
    } t_gen_state;

    t_gen_state gen;
    t_cmd       shadow_cfg;          // registers as written, not yet latched
    t_in_item   pending_items [$];
    t_out_item  expected_tokens [$];
    int         mismatches = 0;
    bit         calm_in, calm_out;   // stretches without idling

    function automatic logic [63:0] lo14(logic [27:0] r); return 64'(r[13:0]);  endfunction
    function automatic logic [63:0] hi14(logic [27:0] r); return 64'(r[27:14]); endfunction

    function automatic int unsigned window_cycles(logic [2:0] k);
        case (k)
            3'd3:    return 9;
            3'd5:    return 25;
            3'd7:    return 49;
            default: return ROWS;
        endcase
    endfunction

    // counts wrap to 16 bits and never drop below one
    function automatic int unsigned clamp_count(logic [63:0] v);
        return (v[15:0] == 16'd0) ? 1 : 32'(v[15:0]);
    endfunction

    function automatic logic [31:0] vert_addr(t_gen_state s);
        logic [63:0] x, xs, cs, xr, cr, flt, off;
        logic        sh;
        sh  = s.cmd.control_flags[2];
        flt = 64'(s.cmd.flow_loop_times);
        xs  = lo14(s.cmd.vertical_steps);
        cs  = hi14(s.cmd.vertical_steps);
        x   = 64'(s.vx);
        // shifted matrix/pointwise: odd channels read the upper eight columns
        if (sh && s.cmd.conv_kernel < 3 && s.vc[0]) x = x + 8;
        xr = (x * xs) & 64'h3fff;
        cr = (64'(s.vc) * cs) & 64'h3fff;
        if (flt == (64'd1 << sh)) off = ((xr * cs) & 64'hfffff) << 4;
        else                      off = ((xs * cr + xr) & 64'hfffff) << 4;
        return BASE + 32'((64'(s.cmd.operand_bases[19:0]) + off) & 64'hfffff);
    endfunction

    function automatic logic [31:0] horiz_addr(t_gen_state s);
        logic [63:0] ch, xs, cs, xr, cr, flt, off;
        logic [1:0]  mode;
        logic        sh, pw;
        mode = s.cmd.control_flags[1:0];
        sh   = s.cmd.control_flags[2];
        flt  = 64'(s.cmd.flow_loop_times);
        pw   = (s.cmd.conv_kernel == 3'd1);
        xs   = lo14(s.cmd.horizontal_steps);
        cs   = hi14(s.cmd.horizontal_steps);
        ch   = pw ? (64'(s.hc) >> sh) : 64'(s.hc);
        xr   = (64'(s.hx) * xs) & 64'h3fff;
        cr   = (ch * cs) & 64'h3fff;
        if (s.cmd.conv_kernel == 3'd0)
            off = (ch + xr) << 4;
        else if ((flt == (64'd1 << sh) || pw) && mode != 2'd2)
            off = ((xr * cs) & 64'hfffff) << 4;
        else
            off = ((xs * cr + xr) & 64'hfffff) << 4;
        return BASE + 32'((64'(s.cmd.operand_bases[39:20]) + off) & 64'hfffff);
    endfunction

    function automatic logic [31:0] out_addr(t_gen_state s);
        logic [63:0] r;
        r = (64'(s.row) * lo14(s.cmd.output_steps) * hi14(s.cmd.output_steps))
            & 64'hfffff;
        return BASE + 32'((64'(s.cmd.result_bases[19:0]) + (r << 4)
                           + (s.high_half ? 64'd16 : 64'd0)) & 64'hfffff);
    endfunction

    // x then channel; returns 1 when the channel loop wraps (stream done)
    function automatic bit advance_stream(inout logic [15:0] x, inout logic [15:0] ch,
                                          inout logic [1:0] fl,
                                          input int unsigned xc, input int unsigned cc);
        x = x + 16'd1;
        if (32'(x) < xc) return 1'b0;
        x  = '0;
        ch = ch + 16'd1;
        if (32'(ch) < cc) return 1'b0;
        ch = '0;
        fl = 2'b00;
        fl[FLAG_DONE] = 1'b1;
        return 1'b1;
    endfunction

    // One item step of the block: returns the outputs seen before the update.
    function automatic t_out_item predict_cycle(t_in_item it);
        t_gen_state  cur, nx;
        t_token      bk, tk;
        t_out_item   o;
        logic [63:0] flt;
        logic [1:0]  mode;
        logic [2:0]  kern;
        logic        sh, st, last;
        int unsigned xc, cc;
        cur = gen;
        nx  = gen;
        bk  = cur.pipe[DEPTH-1];
        o.address             = bk.addr;
        o.read_strobe         = bk.valid && !bk.write;
        o.write_strobe        = bk.valid && bk.write;
        o.read_last           = bk.valid && !bk.write && bk.last;
        o.write_last_out      = bk.valid && bk.write && bk.last;
        o.raw_last            = cur.raw_last;
        o.register_file_clear = cur.reg_clear;

        for (int i = DEPTH - 1; i > 0; i--) nx.pipe[i] = cur.pipe[i-1];
        tk          = '0;
        nx.raw_last = 1'b0;
        nx.prev_lf  = it.last_flow;
        if (o.write_last_out) nx.reg_clear = 1'b1;

        if (it.start_req) begin
            nx.cmd = shadow_cfg;
            nx.vx = '0; nx.vc = '0; nx.hx = '0; nx.hc = '0;
            nx.vf = '0; nx.hf = '0;
            nx.row = 0;
            nx.high_half = 0; nx.bias_active = 0; nx.bias_beat = 0;
            nx.prev_vert = 0; nx.reg_clear = 0;
        end
        // rising last_flow on a convolution starts the two-beat bias fetch
        if (it.last_flow && !cur.prev_lf && cur.cmd.control_flags[4]) begin
            nx.bias_active = 1'b1;
            nx.bias_beat   = 1'b0;
        end

        kern = cur.cmd.conv_kernel;
        mode = cur.cmd.control_flags[1:0];
        sh   = cur.cmd.control_flags[2];
        st   = cur.cmd.control_flags[3];
        flt  = 64'(cur.cmd.flow_loop_times);

        if (it.write_valid) nx.out_active = 1'b1;
        if (cur.out_active || it.write_valid) begin
            // write slot: placed even without write_valid, then invalid
            tk.valid = it.write_valid;
            tk.write = 1'b1;
            tk.addr  = out_addr(cur);
            tk.last  = it.write_last;
            if (it.write_valid) begin
                if (sh && !cur.high_half) begin
                    nx.high_half = 1'b1;
                end else begin
                    nx.high_half = 1'b0;
                    nx.row       = (cur.row + 1) % ROWS;
                end
            end
            if (it.write_last) nx.out_active = 1'b0;
        end else if (cur.bias_active) begin
            tk.valid       = 1'b1;
            tk.addr        = BASE + ((32'(cur.cmd.result_bases[39:20])
                                      + (cur.bias_beat ? 32'd16 : 32'd0)) & 32'hfffff);
            nx.bias_active = !cur.bias_beat;
            nx.bias_beat   = !cur.bias_beat;
        end else if (it.scheduler_busy && !it.last_flow) begin
            if (it.choose_vertical) begin
                if (!cur.prev_vert) nx.vf[FLAG_DONE] = 1'b0;
                if (!nx.vf[FLAG_DONE]) begin
                    if (!nx.vf[FLAG_ACTIVE]) begin
                        nx.vf[FLAG_ACTIVE] = 1'b1;
                        nx.vx = '0;
                        nx.vc = '0;
                    end
                    tk.valid = 1'b1;
                    tk.addr  = vert_addr(cur);
                    xc   = window_cycles(kern);
                    last = (32'(nx.vx) + 1 >= xc);
                    void'(advance_stream(nx.vx, nx.vc, nx.vf, xc, clamp_count(flt >> sh)));
                    tk.last     = last;
                    nx.raw_last = last;
                end
            end else begin
                if (cur.prev_vert) nx.hf[FLAG_DONE] = 1'b0;
                if (!nx.hf[FLAG_DONE]) begin
                    if (!nx.hf[FLAG_ACTIVE]) begin
                        nx.hf[FLAG_ACTIVE] = 1'b1;
                        nx.hx = '0;
                        nx.hc = '0;
                    end
                    tk.valid = 1'b1;
                    tk.addr  = horiz_addr(cur);
                    xc = (kern >= 3) ? ((mode == 2'd2) ? 1 : int'(kern)) : ROWS;
                    if (mode == 2'd2)
                        cc = clamp_count(st ? (((flt << 1) >> sh) + 1) : ((flt >> sh) + 2));
                    else
                        cc = clamp_count(flt >> ((sh && kern >= 3) ? 1 : 0));
                    last        = advance_stream(nx.hx, nx.hc, nx.hf, xc, cc);
                    tk.last     = last;
                    nx.raw_last = last;
                end
            end
            nx.prev_vert = it.choose_vertical;
        end
        nx.pipe[0] = tk;
        gen = nx;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Idle lengths: mostly short, a few long, none in calm stretches.
    // ------------------------------------------------------------------
    function automatic int unsigned idle_len(bit calm);
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // ------------------------------------------------------------------
    // Input driver: one item per push transfer, predictor runs on accept.
    // ------------------------------------------------------------------
    int unsigned in_gap;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push   <= 1'b0;
            in_gap <= 0;
        end else begin
            if (push && !full) expected_tokens.push_back(predict_cycle(i_in));
            if (!push || !full) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    push   <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    i_in   <= pending_items.pop_front();
                    push   <= 1'b1;
                    in_gap <= idle_len(calm_in);
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random pop stalls, in-order field compare.
    // ------------------------------------------------------------------
    int unsigned out_gap;

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            pop     <= 1'b0;
            out_gap <= 0;
        end else begin
            if (pop && !empty) begin
                if (expected_tokens.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: addr %h", o_out.address);
                end else begin
                    want = expected_tokens.pop_front();
                    if (o_out.address             !== want.address        ||
                        o_out.read_strobe         !== want.read_strobe    ||
                        o_out.write_strobe        !== want.write_strobe   ||
                        o_out.read_last           !== want.read_last      ||
                        o_out.write_last_out      !== want.write_last_out ||
                        o_out.raw_last            !== want.raw_last       ||
                        o_out.register_file_clear !== want.register_file_clear) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp addr %h rd %b wr %b rl %b wl %b raw %b clr %b",
                                     want.address, want.read_strobe, want.write_strobe,
                                     want.read_last, want.write_last_out, want.raw_last,
                                     want.register_file_clear,
                                     "\n          got addr %h rd %b wr %b rl %b wl %b raw %b clr %b",
                                     o_out.address, o_out.read_strobe, o_out.write_strobe,
                                     o_out.read_last, o_out.write_last_out, o_out.raw_last,
                                     o_out.register_file_clear);
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                pop     <= 1'b0;
            end else begin
                pop     <= 1'b1;
                out_gap <= idle_len(calm_out);
            end
        end
    end

    // ------------------------------------------------------------------
    // Configuration and stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_CONV_KERNEL:      shadow_cfg.conv_kernel      = data[2:0];
            REG_CONTROL_FLAGS:    shadow_cfg.control_flags    = data[4:0];
            REG_FLOW_LOOP_TIMES:  shadow_cfg.flow_loop_times  = data[15:0];
            REG_VERTICAL_STEPS:   shadow_cfg.vertical_steps   = data[27:0];
            REG_HORIZONTAL_STEPS: shadow_cfg.horizontal_steps = data[27:0];
            REG_OUTPUT_STEPS:     shadow_cfg.output_steps     = data[27:0];
            REG_OPERAND_BASES:    shadow_cfg.operand_bases    = data;
            REG_RESULT_BASES:     shadow_cfg.result_bases     = data;
            default: ;
        endcase
    endtask

    // every item yields a result, so idle means nothing pending or expected
    task automatic drain();
        do @(posedge i_clk);
        while (pending_items.size() > 0 || push || expected_tokens.size() > 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] rnd40();
        return {8'($urandom), 32'($urandom)};
    endfunction

    // fill: 0 all zero, 1 all ones, 2 random with small loop counts
    task automatic load_config(int fill);
        logic [CFG_DATA_W-1:0] ones;
        ones = '1;
        if (fill == 0) begin
            for (int i = 0; i < 8; i++) write_reg(CFG_IDX_W'(i), '0);
        end else if (fill == 1) begin
            for (int i = 0; i < 8; i++) write_reg(CFG_IDX_W'(i), ones);
        end else begin
            write_reg(REG_CONV_KERNEL, CFG_DATA_W'($urandom_range(7)));
            write_reg(REG_CONTROL_FLAGS, CFG_DATA_W'($urandom_range(31)));
            write_reg(REG_FLOW_LOOP_TIMES,
                      CFG_DATA_W'(($urandom_range(9) == 0) ? $urandom_range(65535)
                                                           : $urandom_range(4)));
            write_reg(REG_VERTICAL_STEPS, rnd40());
            write_reg(REG_HORIZONTAL_STEPS, rnd40());
            write_reg(REG_OUTPUT_STEPS, rnd40());
            write_reg(REG_OPERAND_BASES, rnd40());
            write_reg(REG_RESULT_BASES, rnd40());
        end
    endtask

    function automatic t_in_item item(bit s, bit wv, bit wl, bit lf, bit busy, bit cv);
        t_in_item it;
        it.start_req       = s;
        it.write_valid     = wv;
        it.write_last      = wl;
        it.last_flow       = lf;
        it.scheduler_busy  = busy;
        it.choose_vertical = cv;
        return it;
    endfunction

    // start, operand reads, last_flow pulse (bias), result writes, write_last;
    // some noise items mixed in
    task automatic queue_command();
        bit cv;
        int unsigned n;
        pending_items.push_back(item(1, 0, 0, 0, 0, 0));
        cv = $urandom_range(1);
        n  = $urandom_range(4, 40);
        repeat (n) begin
            if ($urandom_range(5) == 0) cv = !cv;
            if ($urandom_range(9) == 0) pending_items.push_back(t_in_item'(6'($urandom)));
            else pending_items.push_back(item(0, 0, 0, 0, $urandom_range(7) != 0, cv));
        end
        repeat ($urandom_range(1, 3))
            pending_items.push_back(item(0, 0, 0, 1, $urandom_range(1), $urandom_range(1)));
        repeat ($urandom_range(0, 4))
            pending_items.push_back(item(0, 0, 0, 0, 1, $urandom_range(1)));
        n = $urandom_range(1, 12);
        repeat (n)
            pending_items.push_back(item(0, $urandom_range(3) != 0, 0, 0,
                                         $urandom_range(1), $urandom_range(1)));
        pending_items.push_back(item(0, 1, 1, 0, $urandom_range(1), $urandom_range(1)));
        repeat ($urandom_range(0, 3))
            pending_items.push_back(item(0, 0, 0, 0, 1, $urandom_range(1)));
    endtask

    initial begin
        int unsigned queued;
        gen           = '{default: '0};
        gen.reg_clear = 1'b1;
        for (int i = 0; i < DEPTH; i++) gen.pipe[i] = '0;
        shadow_cfg  = '0;
        calm_in     = 1'b0;
        calm_out    = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: all-ones config (shift, stride, mode 3, conv, kernel 7)
        load_config(1);
        pending_items.push_back(item(0, 0, 0, 0, 1, 1));   // read before any start
        pending_items.push_back(item(1, 0, 0, 0, 1, 1));   // start with a read
        pending_items.push_back(item(0, 0, 0, 0, 1, 1));
        pending_items.push_back(item(0, 0, 0, 0, 1, 0));   // stream switch
        pending_items.push_back(item(0, 0, 0, 0, 0, 0));   // not busy
        pending_items.push_back(item(0, 0, 0, 1, 1, 0));   // last_flow rise: bias
        pending_items.push_back(item(0, 0, 0, 1, 1, 1));
        pending_items.push_back(item(0, 0, 0, 0, 1, 1));
        pending_items.push_back(item(0, 1, 0, 0, 1, 0));   // write beats
        pending_items.push_back(item(0, 0, 0, 0, 1, 0));   // invalid write slot
        pending_items.push_back(item(0, 1, 0, 0, 0, 0));
        pending_items.push_back(item(1, 1, 0, 0, 0, 0));   // start during a write
        pending_items.push_back(item(0, 1, 1, 1, 1, 1));   // final write
        pending_items.push_back(item(0, 0, 0, 0, 0, 0));
        pending_items.push_back(item(0, 0, 0, 0, 0, 0));
        pending_items.push_back(item(0, 0, 0, 0, 1, 1));
        drain();
        // directed: all-zero config, matrix kernel
        load_config(0);
        pending_items.push_back(item(1, 0, 0, 0, 0, 0));
        repeat (3) pending_items.push_back(item(0, 0, 0, 0, 1, 0));
        repeat (3) pending_items.push_back(item(0, 0, 0, 0, 1, 1));
        pending_items.push_back(item(0, 1, 1, 0, 0, 0));
        drain();

        // random phases; the sender holds off at each drain
        queued = 0;
        while (queued < 700) begin
            calm_in  = ($urandom_range(3) == 0);
            calm_out = ($urandom_range(3) == 0);
            load_config(($urandom_range(7) == 0) ? $urandom_range(1) : 2);
            repeat ($urandom_range(1, 3)) queue_command();
            queued += pending_items.size();
            drain();
        end
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_tokens.size() == 0) begin
            $display("** conv_array_address_generator: PASSED **");
        end else begin
            $display("** conv_array_address_generator: FAILED **");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout");
        $display("** conv_array_address_generator: FAILED **");
        $finish;
    end

endmodule
